@@ hw/rtl/tkbd_pkg.sv @@
// Shared types and constants for the touch key baseline detector.
// No dependencies; tkbd_front, tkbd_back and the top level import this package.
package tkbd_pkg;

    // Field width of counts on the ports
    localparam int unsigned FIELD_W      = 16;

    // Calibration and scan constants
    localparam int unsigned CAL_COUNT    = 10;
    localparam int unsigned IDX_W        = $clog2(CAL_COUNT);
    localparam int unsigned MID_FIRST    = 2;
    localparam int unsigned MID_COUNT    = 6;
    localparam int unsigned MID_W        = $clog2(MID_COUNT);
    localparam int unsigned DIVISOR      = 6;
    localparam int unsigned GROUP_NORMAL = 3;
    localparam int unsigned GROUP_REPEAT = 6;
    localparam int unsigned SCAN_W       = 3;
    localparam int unsigned LOCKOUT_SET  = 3;
    localparam int unsigned LOCK_W       = 2;
    localparam int unsigned GATE_RESET   = 100;

    // Configuration register indexes
    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_GATE_MARGIN = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_MODE = 1'b1;

    // Result kinds
    localparam logic KIND_CAL  = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    // Sample actions
    typedef enum logic [0:0] {
        OP_CAL  = 1'b0,
        OP_SCAN = 1'b1
    } op_t;

    // Executer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] charge_count;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic               pressed;
        logic               fault;
        logic [FIELD_W-1:0] baseline;
        logic [FIELD_W-1:0] peak;
    } out_item_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t                op;
        logic [FIELD_W-1:0] sample;
    } cmd_t;

    // Configuration seen by the executer
    typedef struct packed {
        logic [FIELD_W-1:0] gate_margin;
        logic               repeat_mode;
    } cfg_t;

endpackage

@@ hw/rtl/tkbd_fifo.sv @@
// Small synchronous queue of flip-flop entries with push/pop handshake.
// Depends on nothing; used for the command queue and the result queue.
module tkbd_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/tkbd_front.sv @@
// Front end: accepts input transactions, classifies them into commands
// and queues them for the executer. Depends on tkbd_pkg and tkbd_fifo.
module tkbd_front
    import tkbd_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    localparam int unsigned SW = (SAMPLE_WIDTH < FIELD_W) ? SAMPLE_WIDTH : FIELD_W;

    cmd_t cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_bits;
    logic cmd_empty;

    // Classify and drop count bits above the sample width
    always_comb
    begin
        cmd_in.op     = op_t'(item.action);
        cmd_in.sample = FIELD_W'(item.charge_count[SW-1:0]);
    end

    tkbd_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_bits),
        .empty   (cmd_empty)
    );

    assign cmd       = cmd_t'(cmd_bits);
    assign cmd_valid = !cmd_empty;

endmodule

@@ hw/rtl/tkbd_back.sv @@
// Back end: executes calibration and scan commands, keeps the sorted
// calibration set, baseline, scan group and lockout. Depends on tkbd_pkg.
module tkbd_back
    import tkbd_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res
);

    localparam int unsigned SW      = (SAMPLE_WIDTH < FIELD_W) ? SAMPLE_WIDTH : FIELD_W;
    localparam int unsigned SUMW    = SW + 3;
    localparam int unsigned CMP_W   = FIELD_W + 1;
    localparam int unsigned TEN_W   = SW + 4;
    localparam bit          FAULT_EN = (SAMPLE_WIDTH <= FIELD_W);
    // Reciprocal of six, exact for every sum below 2**SUMW
    localparam int unsigned RECIP_SHIFT = SUMW + 2;
    localparam int unsigned RECIP   = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int unsigned PROD_W  = 2 * SUMW;

    state_t state_reg, state_next;

    logic [SW-1:0]     sorted_reg [CAL_COUNT];
    logic [SW-1:0]     sorted_next [CAL_COUNT];
    logic [IDX_W-1:0]  cal_cnt_reg, cal_cnt_next;
    logic [SW-1:0]     baseline_reg, baseline_next;
    logic [SW-1:0]     scan_peak_reg, scan_peak_next;
    logic [SCAN_W-1:0] scan_idx_reg, scan_idx_next;
    logic [LOCK_W-1:0] lockout_reg, lockout_next;
    logic [MID_W-1:0]  mid_idx_reg, mid_idx_next;
    logic [SUMW-1:0]   sum_reg, sum_next;
    out_item_t         res_reg, res_next;

    logic [SW-1:0]     sample;
    logic [CAL_COUNT-1:0] le;
    logic              cal_last;
    logic [SW-1:0]     peak_upd;
    logic [SCAN_W-1:0] scan_idx_inc;
    logic [SCAN_W-1:0] group_size;
    logic              scan_done;
    logic [CMP_W-1:0]  gate_level;
    logic [TEN_W-1:0]  ten_base;
    logic              qualifies;
    logic [LOCK_W-1:0] lock_pre;
    logic [LOCK_W-1:0] lock_set;
    logic              mid_last;
    logic [SUMW-1:0]   sum_add;
    logic [PROD_W-1:0] prod;
    logic [SW-1:0]     quot;

    assign sample = cmd.sample[SW-1:0];

    // Sorted insertion: entries at or below the sample stay, the rest move up
    always_comb
    begin
        for (int i = 0; i < CAL_COUNT; i++)
        begin
            le[i] = (IDX_W'(i) < cal_cnt_reg) && (sorted_reg[i] <= sample);
        end
    end

    assign cal_last = (cal_cnt_reg == IDX_W'(CAL_COUNT - 1));

    // Scan group and press decision
    assign peak_upd     = (sample > scan_peak_reg) ? sample : scan_peak_reg;
    assign scan_idx_inc = scan_idx_reg + 1'b1;
    assign group_size   = cfg.repeat_mode ? SCAN_W'(GROUP_REPEAT) : SCAN_W'(GROUP_NORMAL);
    assign scan_done    = (scan_idx_inc >= group_size);
    assign gate_level   = CMP_W'(baseline_reg) + CMP_W'(cfg.gate_margin);
    assign ten_base     = TEN_W'({baseline_reg, 3'b000}) + TEN_W'({baseline_reg, 1'b0});
    assign qualifies    = (CMP_W'(peak_upd) > gate_level) && (TEN_W'(peak_upd) < ten_base);
    assign lock_pre     = cfg.repeat_mode ? '0 : lockout_reg;
    assign lock_set     = qualifies ? LOCK_W'(LOCKOUT_SET) : lock_pre;

    // Middle-six sum, one sorted entry per cycle
    assign mid_last = (mid_idx_reg == MID_W'(MID_COUNT - 1));
    assign sum_add  = sum_reg + SUMW'(sorted_reg[IDX_W'(MID_FIRST) + IDX_W'(mid_idx_reg)]);

    // Division by six as a multiply by the scaled reciprocal
    assign prod = PROD_W'(sum_reg) * PROD_W'(SUMW'(RECIP));
    assign quot = prod[RECIP_SHIFT +: SW];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_CAL)
                    begin
                        if (cal_last)
                        begin
                            state_next = ST_SUM;
                        end
                    end
                    else if (scan_done)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SUM:
            begin
                if (mid_last)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_pop  = cmd_valid;
            ST_EMIT: res_push = !res_full;
            default:
            begin
                cmd_pop  = 1'b0;
                res_push = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    // Datapath next values
    always_comb
    begin
        sorted_next    = sorted_reg;
        cal_cnt_next   = cal_cnt_reg;
        baseline_next  = baseline_reg;
        scan_peak_next = scan_peak_reg;
        scan_idx_next  = scan_idx_reg;
        lockout_next   = lockout_reg;
        mid_idx_next   = mid_idx_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;

        if ((state_reg == ST_IDLE) && cmd_valid)
        begin
            if (cmd.op == OP_CAL)
            begin
                sorted_next[0] = le[0] ? sorted_reg[0] : sample;
                for (int i = 1; i < CAL_COUNT; i++)
                begin
                    if (le[i])
                    begin
                        sorted_next[i] = sorted_reg[i];
                    end
                    else if (le[i-1])
                    begin
                        sorted_next[i] = sample;
                    end
                    else
                    begin
                        sorted_next[i] = sorted_reg[i-1];
                    end
                end
                if (cal_last)
                begin
                    cal_cnt_next = '0;
                    sum_next     = '0;
                    mid_idx_next = '0;
                end
                else
                begin
                    cal_cnt_next = cal_cnt_reg + 1'b1;
                end
            end
            else if (scan_done)
            begin
                scan_peak_next   = '0;
                scan_idx_next    = '0;
                lockout_next     = (lock_set != '0) ? lock_set - 1'b1 : lock_set;
                res_next.kind     = KIND_SCAN;
                res_next.pressed  = qualifies && (lock_pre == '0);
                res_next.fault    = 1'b0;
                res_next.baseline = FIELD_W'(baseline_reg);
                res_next.peak     = FIELD_W'(peak_upd);
            end
            else
            begin
                scan_peak_next = peak_upd;
                scan_idx_next  = scan_idx_inc;
            end
        end

        if (state_reg == ST_SUM)
        begin
            sum_next     = sum_add;
            mid_idx_next = mid_idx_reg + 1'b1;
        end

        if (state_reg == ST_DIV)
        begin
            baseline_next     = quot;
            res_next.kind     = KIND_CAL;
            res_next.pressed  = 1'b0;
            res_next.fault    = FAULT_EN ? quot[SW-1] : 1'b0;
            res_next.baseline = FIELD_W'(quot);
            res_next.peak     = '0;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cal_cnt_reg   <= '0;
            baseline_reg  <= '0;
            scan_peak_reg <= '0;
            scan_idx_reg  <= '0;
            lockout_reg   <= '0;
            mid_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cal_cnt_reg   <= cal_cnt_next;
            baseline_reg  <= baseline_next;
            scan_peak_reg <= scan_peak_next;
            scan_idx_reg  <= scan_idx_next;
            lockout_reg   <= lockout_next;
            mid_idx_reg   <= mid_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sorted_reg  <= sorted_next;
        sum_reg     <= sum_next;
        res_reg     <= res_next;
    end

endmodule

@@ hw/rtl/touch_key_baseline_detector_unit.sv @@
// Top level of the touch key baseline detector: configuration registers,
// front end, executer and result queue. Depends on tkbd_pkg and all tkbd_* modules.
//
// Capacitive touch key detector. Calibration samples (action 0) are kept in a
// sorted set as they arrive; the tenth one starts a pass that adds the middle
// six sorted counts, one per cycle, and divides the sum by six with one
// reciprocal multiply, giving the new baseline and a fault flag when it reaches
// half the count range. Scan samples (action 1) track the peak of a group of
// three, or six in repeat mode, and the last sample of a group yields a press
// decision. Inputs go through a two-entry command queue and results through a
// two-entry result queue, so either side may stall on its own. The executer
// accepts each sample in its idle state and posts a scan decision from an emit
// state that waits while the result queue is full; the tenth calibration sample
// also passes the six-step sum and the multiply first. Only the low SAMPLE_WIDTH
// bits of a count are used, and at most 16.
module touch_key_baseline_detector_unit
    import tkbd_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  in_item_t             item,
    output logic                 full,
    input  logic                 pop,
    output out_item_t            result,
    output logic                 empty,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    logic [FIELD_W-1:0] gate_margin_reg, gate_margin_next;
    logic               repeat_mode_reg, repeat_mode_next;
    cfg_t               cfg;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;
    logic               res_full;
    logic               res_push;
    out_item_t          res;
    logic [$bits(out_item_t)-1:0] res_bits;

    // Configuration register decode
    always_comb
    begin
        gate_margin_next = gate_margin_reg;
        repeat_mode_next = repeat_mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GATE_MARGIN: gate_margin_next = cfg_data;
                REG_REPEAT_MODE: repeat_mode_next = cfg_data[0];
                default:
                begin
                    gate_margin_next = gate_margin_reg;
                    repeat_mode_next = repeat_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_margin_reg <= FIELD_W'(GATE_RESET);
            repeat_mode_reg <= 1'b0;
        end
        else
        begin
            gate_margin_reg <= gate_margin_next;
            repeat_mode_reg <= repeat_mode_next;
        end
    end

    always_comb
    begin
        cfg.gate_margin = gate_margin_reg;
        cfg.repeat_mode = repeat_mode_reg;
    end

    tkbd_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tkbd_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // Result queue towards the consumer
    tkbd_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign result = out_item_t'(res_bits);

endmodule

@@ verif/tkbd_checker.sv @@
// Checker for the touch key baseline detector: watches the sample, result and
// configuration ports, predicts each result and compares it field by field.
// Depends on tkbd_pkg.
`timescale 1ns / 1ps

module tkbd_checker
    import tkbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  in_item_t             item,
    input  logic                 full,
    input  logic                 pop,
    input  out_item_t            result,
    input  logic                 empty,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   pending
);

    // Configuration copy
    logic [FIELD_W-1:0] gate_margin;
    logic               repeat_mode;

    // Detector state copy
    logic [FIELD_W-1:0] baseline;
    logic [LOCK_W-1:0]  lockout;
    logic [FIELD_W-1:0] cal_store [CAL_COUNT];
    int unsigned        cal_idx;
    logic [SCAN_W-1:0]  scan_idx;
    logic [FIELD_W-1:0] scan_peak;

    // Decisions still owed by the block, oldest first
    out_item_t owed_results [$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("checker: %s mismatch at %0t: got %0d, expected %0d",
                 what, $time, got, want);
        fail_count++;
    endtask

    // Sort the ten calibration counts and average the middle six
    function automatic logic [FIELD_W-1:0] middle_mean();
        logic [FIELD_W-1:0] s [CAL_COUNT];
        logic [FIELD_W-1:0] v;
        int unsigned        sum;
        int                 b;
        s = cal_store;
        sum = 0;
        for (int a = 1; a < CAL_COUNT; a++)
        begin
            v = s[a];
            b = a;
            while (b > 0 && s[b-1] > v)
            begin
                s[b] = s[b-1];
                b--;
            end
            s[b] = v;
        end
        for (int a = MID_FIRST; a < MID_FIRST + MID_COUNT; a++)
            sum += s[a];
        return FIELD_W'(sum / DIVISOR);
    endfunction

    // Advance the detector copy by one accepted sample
    task automatic take_sample(input in_item_t it);
        out_item_t   r;
        int unsigned group;
        int unsigned peak;
        if (it.action == OP_CAL)
        begin
            if (cal_idx >= CAL_COUNT)
                cal_idx = 0;
            cal_store[cal_idx] = it.charge_count;
            cal_idx++;
            if (cal_idx == CAL_COUNT)
            begin
                cal_idx = 0;
                baseline = middle_mean();
                r = '0;
                r.kind = KIND_CAL;
                r.fault = (baseline > 16'h7fff);
                r.baseline = baseline;
                owed_results.push_back(r);
            end
        end
        else
        begin
            group = repeat_mode ? GROUP_REPEAT : GROUP_NORMAL;
            if (it.charge_count > scan_peak)
                scan_peak = it.charge_count;
            scan_idx++;
            if (scan_idx >= group)
            begin
                peak = scan_peak;
                scan_idx = '0;
                scan_peak = '0;
                r = '0;
                r.kind = KIND_SCAN;
                if (repeat_mode)
                    lockout = '0;
                if (peak > int'(baseline) + int'(gate_margin) && peak < 10 * int'(baseline))
                begin
                    if (lockout == 0)
                        r.pressed = 1'b1;
                    lockout = LOCK_W'(LOCKOUT_SET);
                end
                if (lockout != 0)
                    lockout--;
                r.baseline = baseline;
                r.peak = FIELD_W'(peak);
                owed_results.push_back(r);
            end
        end
    endtask

    // Compare one delivered decision with the oldest owed one
    task automatic match_result(input out_item_t got);
        out_item_t want;
        if (owed_results.size() == 0)
        begin
            report_mismatch("unexpected result (kind)", got.kind, 0);
            return;
        end
        want = owed_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", got.kind, want.kind);
        if (got.pressed !== want.pressed)
            report_mismatch("pressed", got.pressed, want.pressed);
        if (got.fault !== want.fault)
            report_mismatch("fault", got.fault, want.fault);
        if (got.baseline !== want.baseline)
            report_mismatch("baseline", got.baseline, want.baseline);
        if (got.peak !== want.peak)
            report_mismatch("peak", got.peak, want.peak);
    endtask

    // Sample every transaction at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_margin = FIELD_W'(GATE_RESET);
            repeat_mode = 1'b0;
            baseline = '0;
            lockout = '0;
            cal_idx = 0;
            scan_idx = '0;
            scan_peak = '0;
            foreach (cal_store[i])
                cal_store[i] = '0;
            owed_results.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GATE_MARGIN: gate_margin = cfg_data;
                    REG_REPEAT_MODE: repeat_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (pop && !empty)
                match_result(result);
            if (push && !full)
                take_sample(item);
            pending = owed_results.size();
        end
    end

endmodule

@@ verif/touch_key_baseline_detector_unit_test.sv @@
// Testbench top for the touch key baseline detector: clock, reset, sample and
// configuration stimulus, result draining and the verdict.
// Depends on tkbd_pkg, touch_key_baseline_detector_unit and tkbd_checker.
`timescale 1ns / 1ps

module touch_key_baseline_detector_unit_test;
    import tkbd_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int MAX_IDLE      = 11;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    in_item_t             item = '0;
    logic                 full;
    logic                 pop = 1'b0;
    out_item_t            result;
    logic                 empty;
    logic                 cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = REG_GATE_MARGIN;
    logic [FIELD_W-1:0]   cfg_data = '0;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    int          gap_max = MAX_IDLE;
    int          stall_max = MAX_IDLE;
    bit          hold_req = 1'b0;
    int unsigned cur_gate = GATE_RESET;
    bit          cur_rep = 1'b0;
    int unsigned centre = 0;

    touch_key_baseline_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tkbd_checker watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .pop        (pop),
        .result     (result),
        .empty      (empty),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned clamp_count(input int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    // Untouched level for the next calibration
    function automatic int unsigned pick_centre();
        case ($urandom_range(9))
            0:       return $urandom_range(20);
            6, 7:    return $urandom_range(20000, 5000);
            8:       return $urandom_range(40000, 30000);
            9:       return $urandom_range(65535, 60000);
            default: return $urandom_range(3000, 50);
        endcase
    endfunction

    function automatic int unsigned cal_count(input int unsigned mid);
        case ($urandom_range(19))
            0:       return 0;
            1:       return 65535;
            default: return clamp_count(int'(mid) + int'($urandom_range(120)) - 60);
        endcase
    endfunction

    // Scan counts cluster round the press threshold and the upper bound
    function automatic int unsigned scan_count(input int unsigned mid, input int unsigned gate);
        case ($urandom_range(9))
            0:       return $urandom_range(65535);
            1:       return $urandom_range(1) ? 65535 : 0;
            2, 3, 4: return clamp_count(int'(mid) + int'($urandom_range(40)) - 20);
            9:       return clamp_count(10 * int'(mid) + int'($urandom_range(6)) - 3);
            default: return clamp_count(int'(mid) + int'(gate) + int'($urandom_range(200)) - 100);
        endcase
    endfunction

    // Offer one sample and hold it until the block takes it
    task automatic send_sample(input op_t act, input int unsigned count);
        in_item_t v;
        int       gap;
        v.action = act;
        v.charge_count = count[FIELD_W-1:0];
        gap = $urandom_range(gap_max);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= v;
        do @(posedge clk); while (full);
    endtask

    // Stop offering and wait for every owed decision, then let the block go quiet
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int unsigned gate, input bit rep);
        cfg_we <= 1'b1;
        cfg_index <= REG_GATE_MARGIN;
        cfg_data <= gate[FIELD_W-1:0];
        @(posedge clk);
        cfg_index <= REG_REPEAT_MODE;
        cfg_data <= {(FIELD_W-1)'($urandom), rep};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_gate = gate;
        cur_rep = rep;
    endtask

    // Mostly whole calibration runs and scan groups, with stray samples mixed in
    task automatic run_phase(input int n);
        int count;
        int size;
        int r;
        count = 0;
        while (count < n)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                centre = pick_centre();
                repeat (CAL_COUNT)
                    send_sample(OP_CAL, cal_count(centre));
                count += CAL_COUNT;
            end
            else if (r < 85)
            begin
                size = cur_rep ? GROUP_REPEAT : GROUP_NORMAL;
                repeat (size)
                begin
                    if ($urandom_range(19) == 0)
                    begin
                        send_sample(OP_CAL, cal_count(centre));
                        count++;
                    end
                    send_sample(OP_SCAN, scan_count(centre, cur_gate));
                    count++;
                end
            end
            else
            begin
                send_sample(op_t'($urandom_range(1)), $urandom_range(65535));
                count++;
            end
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        bit held;
        held = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = $urandom_range(stall_max);
                if (stall > 0)
                begin
                    pop <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    // Sample side and verdict
    initial
    begin
        int unsigned cal_set [CAL_COUNT] = '{65535, 0, 1200, 1000, 1100,
                                             900, 1050, 0, 65535, 950};
        int unsigned gate_tbl [PHASES] = '{100, 0, 65535, 250, 20, 1000, 65535, 0};
        bit          rep_tbl [PHASES]  = '{0, 1, 1, 0, 1, 0, 0, 1};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero baseline after reset: nothing can qualify
        send_sample(OP_SCAN, 0);
        send_sample(OP_SCAN, 65535);
        send_sample(OP_SCAN, 5);
        // Calibration with outliers at both ends
        foreach (cal_set[i])
            send_sample(OP_CAL, cal_set[i]);
        // A press, then the same peak again under lockout
        send_sample(OP_SCAN, 1300);
        send_sample(OP_SCAN, 1200);
        send_sample(OP_SCAN, 1250);
        send_sample(OP_SCAN, 1250);
        send_sample(OP_SCAN, 1300);
        send_sample(OP_SCAN, 1180);
        // Group of six cut short by a switch back to groups of three
        drain();
        set_config(GATE_RESET, 1'b1);
        send_sample(OP_SCAN, 1100);
        send_sample(OP_SCAN, 1150);
        send_sample(OP_SCAN, 1120);
        send_sample(OP_SCAN, 1130);
        drain();
        set_config(GATE_RESET, 1'b0);
        send_sample(OP_SCAN, 1400);

        // Random phases over a spread of settings
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_config(gate_tbl[p], rep_tbl[p]);
            gap_max = (p % 4 == 3) ? 0 : MAX_IDLE;
            stall_max = (p % 4 == 3) ? 0 : MAX_IDLE;
            if (p == 1)
                hold_req = 1'b1;
            run_phase(PHASE_ITEMS);
            // leave a part-filled scan group for the next setting
            repeat ($urandom_range(4))
                send_sample(OP_SCAN, scan_count(centre, cur_gate));
        end

        drain();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
